// ----- rtl/bda_pkg.sv -----
// ----------------------------------------------------------------------------
// bda_pkg: shared definitions for the button debounce / auto-repeat block
// Phase codes, register indexes, reset values and the button encoder.
// ----------------------------------------------------------------------------
package bda_pkg;

  localparam int NumButtons = 5;
  localparam int PinW       = 5;
  localparam int CodeW      = 3;
  localparam int PhaseW     = 2;
  localparam int EnW        = 6;
  localparam int TimeW      = 10;
  localparam int CountW     = 11;
  localparam int CfgIdxW    = 2;

  // debouncer phases
  localparam logic [PhaseW-1:0] PhaseIdle    = 2'd0;
  localparam logic [PhaseW-1:0] PhaseConfirm = 2'd1;
  localparam logic [PhaseW-1:0] PhaseHeld    = 2'd2;

  // opcodes
  localparam logic OpTick = 1'b0;
  localparam logic OpRead = 1'b1;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegRepeatEnable = 2'd0;
  localparam logic [CfgIdxW-1:0] RegFirstDelay   = 2'd1;
  localparam logic [CfgIdxW-1:0] RegMinInterval  = 2'd2;
  localparam logic [CfgIdxW-1:0] RegIntervalStep = 2'd3;

  // register reset values
  localparam logic [EnW-1:0]   RepeatEnableRst = 6'd0;
  localparam logic [TimeW-1:0] FirstDelayRst   = 10'd160;
  localparam logic [TimeW-1:0] MinIntervalRst  = 10'd30;
  localparam logic [TimeW-1:0] IntervalStepRst = 10'd16;

  typedef struct packed {
    logic [CodeW-1:0]  press_code;
    logic [PhaseW-1:0] phase;
  } result_t;

  // lowest pressed button wins; pins are active low
  function automatic logic [CodeW-1:0] encode_buttons(input logic [PinW-1:0] levels);
    logic [PinW-1:0]  pressed;
    logic [CodeW-1:0] code;
    pressed = ~levels;
    code    = '0;
    for (int i = PinW - 1; i >= 0; i--) begin
      if (pressed[i] && (i < NumButtons)) begin
        code = CodeW'(i + 1);
      end
    end
    return code;
  endfunction

endpackage

// ----- rtl/button_debounce_autorepeat.sv -----
// ----------------------------------------------------------------------------
// button_debounce_autorepeat: debouncer with accelerating auto-repeat
// Priority-encodes five active-low pins, confirms a press over two ticks and
// fires auto-repeats at shrinking intervals; read items fetch and clear the
// pending press code.
// ----------------------------------------------------------------------------
// channel   dir  handshake                        payload
// s_axis    in   s_axis_tvalid / s_axis_tready    tdata: pin_levels, tuser: opcode
// m_axis    out  m_axis_tvalid / m_axis_tready    tdata: press_code, phase
// cfg       in   cfg_valid_i / cfg_ready_o        cfg_index_i, cfg_data_i
//
// One item per clock while s_axis_tready is high; the result is registered in the output register, or in the skid
// entry when the output is stalled. The state update is a single compare/decrement/mux pass on the accept edge.
// A two-entry output buffer (output register plus skid) keeps s_axis_tready
// high while m_axis stalls; it drops only when both are full.
// Reset clears the debouncer state and loads the register defaults.
// Config writes are always accepted (cfg_ready_o is tied high).
// ----------------------------------------------------------------------------
module button_debounce_autorepeat (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,   // [4:0] pin_levels, [7:5] zero
  input  logic                        s_axis_tuser,   // [0] opcode
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [7:0]                  m_axis_tdata,   // [2:0] press_code, [4:3] phase,
                                                      // [7:5] zero
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [bda_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [bda_pkg::TimeW-1:0]   cfg_data_i
);
  import bda_pkg::*;

  // configuration
  logic [EnW-1:0]   repeat_enable_q;
  logic [TimeW-1:0] first_delay_q, min_interval_q, interval_step_q;

  // debouncer state
  logic [PhaseW-1:0] phase_q, phase_d;
  logic [CodeW-1:0]  cand_q, cand_d;
  logic [CodeW-1:0]  pending_q, pending_d;
  logic [CountW-1:0] countdown_q, countdown_d;
  logic [CountW-1:0] interval_q, interval_d;

  // output buffer
  logic    out_valid_q, skid_valid_q;
  result_t out_q, skid_q;
  result_t result;

  logic in_xfer, out_pop;
  logic [CodeW-1:0]  code;
  logic [CountW-1:0] cd_loaded;
  logic [CountW:0]   shrink_limit;
  logic [7:0]        enable_vec;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = ~skid_valid_q;
  assign in_xfer       = s_axis_tvalid & s_axis_tready;
  assign out_pop       = out_valid_q & m_axis_tready;

  assign code         = encode_buttons(s_axis_tdata[PinW-1:0]);
  assign shrink_limit = {2'b00, interval_step_q} + {2'b00, min_interval_q};
  assign enable_vec   = {2'b00, repeat_enable_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      repeat_enable_q <= RepeatEnableRst;
      first_delay_q   <= FirstDelayRst;
      min_interval_q  <= MinIntervalRst;
      interval_step_q <= IntervalStepRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegRepeatEnable: repeat_enable_q <= cfg_data_i[EnW-1:0];
        RegFirstDelay:   first_delay_q   <= cfg_data_i;
        RegMinInterval:  min_interval_q  <= cfg_data_i;
        RegIntervalStep: interval_step_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_d     = phase_q;
    cand_d      = cand_q;
    pending_d   = pending_q;
    countdown_d = countdown_q;
    interval_d  = interval_q;
    cd_loaded   = countdown_q;
    result.press_code = '0;
    if (s_axis_tuser == OpRead) begin
      result.press_code = pending_q;
      pending_d         = '0;
    end else begin
      case (phase_q)
        PhaseConfirm: begin
          if (code == cand_q) begin
            pending_d   = cand_q;
            countdown_d = {1'b0, first_delay_q};
            if (first_delay_q >= interval_step_q) begin
              interval_d = {1'b0, first_delay_q - interval_step_q};
            end else begin
              interval_d = '0;
            end
            phase_d = PhaseHeld;
          end else begin
            phase_d = PhaseIdle;
          end
        end
        PhaseHeld: begin
          if (code == '0) begin
            phase_d = PhaseIdle;
          end else begin
            if (countdown_q == '0) begin
              cd_loaded = interval_q;
              if ({1'b0, interval_q} >= shrink_limit) begin
                interval_d = interval_q - {1'b0, interval_step_q};
              end else begin
                interval_d = {1'b0, min_interval_q};
              end
              if (enable_vec[cand_q]) begin
                pending_d = cand_q;
              end
            end
            countdown_d = (cd_loaded != '0) ? cd_loaded - 1'b1 : cd_loaded;
          end
        end
        default: begin
          cand_d  = code;
          phase_d = (code != '0) ? PhaseConfirm : PhaseIdle;
        end
      endcase
    end
    result.phase = phase_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhaseIdle;
      cand_q      <= '0;
      pending_q   <= '0;
      countdown_q <= '0;
      interval_q  <= '0;
    end else if (in_xfer) begin
      phase_q     <= phase_d;
      cand_q      <= cand_d;
      pending_q   <= pending_d;
      countdown_q <= countdown_d;
      interval_q  <= interval_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        if (!out_valid_q || out_pop) begin
          out_valid_q <= 1'b1;
        end else begin
          skid_valid_q <= 1'b1;
        end
      end else if (out_pop) begin
        out_valid_q  <= skid_valid_q;
        skid_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      if (!out_valid_q || out_pop) begin
        out_q <= result;
      end else begin
        skid_q <= result;
      end
    end else if (out_pop && skid_valid_q) begin
      out_q <= skid_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_q.phase, out_q.press_code};

  // skid holds data only behind a full output register
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry valid while output register empty");

  // held phase always tracks a real button
  a_held_has_cand: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhaseHeld) |-> (cand_q != '0))
    else $error("held phase with zero candidate code");

  // a read clears the pending press
  a_read_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && (s_axis_tuser == OpRead)) |=> (pending_q == '0))
    else $error("pending press not cleared by read");

  // a parked skid entry stays put until the output drains
  a_skid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && !out_pop) |=> (skid_valid_q && $stable(skid_q)))
    else $error("skid entry changed while output stalled");

endmodule
